// File: design/aad_pkg.sv
// Package for the area-average downscaler.
// Holds field widths, register indexes, reset values and the controller/datapath structs.
// No dependencies.
`default_nettype none
package aad_pkg;
    localparam int SRC_W      = 13;
    localparam int DST_W      = 12;
    localparam int PIX_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

    localparam logic [SRC_W-1:0] RST_SRC_WIDTH  = 13'd1024;
    localparam logic [SRC_W-1:0] RST_SRC_HEIGHT = 13'd1024;
    localparam logic [DST_W-1:0] RST_DST_WIDTH  = 12'd512;
    localparam logic [DST_W-1:0] RST_DST_HEIGHT = 12'd512;

    localparam logic [1:0] TERM_LAST = 2'd3;

    typedef struct packed {
        logic       clr;
        logic       load;
        logic       mul1;
        logic       mul2;
        logic       wr;
        logic       last;
        logic       div_start;
        logic       out_load;
        logic [1:0] term;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic cfg_ok;
        logic emit;
        logic div_done;
        logic out_full;
    } t_sts;
endpackage
`default_nettype wire

// File: design/aad_div.sv
// Restoring divider, one quotient bit per cycle.
// Uses no package items.
`default_nettype none
module aad_div #(
    parameter int N = 41,
    parameter int M = 26
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [N-1:0] i_dividend,
    input  wire logic [M-1:0] i_divisor,
    output logic              o_done,
    output logic [N-1:0]      o_quotient
);
    localparam int CNT_W = $clog2(N + 1);

    logic [M-1:0]     r_rem;
    logic [N-1:0]     r_quo;
    logic [M-1:0]     r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [M:0]       shifted;
    logic [M+1:0]     diff;
    logic             ge;

    always_comb begin
        shifted = {r_rem, r_quo[N-1]};
        diff    = {1'b0, shifted} - {2'b00, r_dvs};
        ge      = !diff[M+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_rem  <= '0;
            r_quo  <= i_dividend;
            r_dvs  <= i_divisor;
            r_cnt  <= CNT_W'(N);
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[M-1:0] : shifted[M-1:0];
            r_quo <= {r_quo[N-2:0], ge};
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule
`default_nettype wire

// File: design/aad_dp.sv
// Datapath: config registers, position counters, weight multipliers, row store,
// divider and output register. Depends on aad_pkg and aad_div.
`default_nettype none
module aad_dp #(
    parameter int MAX_DST_WIDTH = 4096,
    parameter int MAX_SRC_SIZE  = 4096,
    parameter int SAMPLE_BITS   = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire aad_pkg::t_cmd                  i_cmd,
    output aad_pkg::t_sts                       o_sts,
    input  wire logic                           i_cfg_fire,
    input  wire logic [aad_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [aad_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [aad_pkg::PIX_W-1:0]      i_sample,
    input  wire logic                           i_out_ready,
    output logic                                o_out_valid,
    output logic [aad_pkg::PIX_W-1:0]           o_pixel_value,
    output logic [aad_pkg::DST_W-1:0]           o_out_x,
    output logic [aad_pkg::DST_W-1:0]           o_out_y,
    output logic                                o_frame_done
);
    import aad_pkg::*;

    localparam int CW        = $clog2(MAX_DST_WIDTH);
    localparam int AW        = CW + 1;
    localparam int DEPTH     = 2 ** AW;
    localparam int ACC_BITS  = SAMPLE_BITS + 2 * $clog2(MAX_SRC_SIZE);
    localparam int AREA_BITS = 2 * SRC_W;
    localparam int DIVD_BITS = ACC_BITS + 1;
    localparam int P1_W      = PIX_W + DST_W;
    localparam logic [PIX_W-1:0] SMASK = PIX_W'((64'd1 << SAMPLE_BITS) - 64'd1);

    logic [SRC_W-1:0] r_src_w, r_src_h;
    logic [DST_W-1:0] r_dst_w, r_dst_h;
    logic [SRC_W-1:0] r_in_col, r_in_row, r_col_ph, r_row_ph;
    logic [DST_W-1:0] r_lo_col, r_lo_row;

    logic [PIX_W-1:0]     r_s;
    logic [DST_W-1:0]     r_wx [2];
    logic [DST_W-1:0]     r_wy [2];
    logic                 r_emit, r_fdone, r_base_row0;
    logic [DST_W-1:0]     r_ex, r_ey;
    logic [AREA_BITS-1:0] r_area;
    logic [P1_W-1:0]      r_p1;
    logic [ACC_BITS-1:0]  r_p2;
    logic [AW-1:0]        r_addr;
    logic                 r_wen_ok;
    logic [ACC_BITS-1:0]  r_rdata;
    logic [ACC_BITS-1:0]  r_sum;
    logic [AW-1:0]        r_clr_addr;
    logic [ACC_BITS-1:0]  r_mem [DEPTH];

    logic                 r_out_valid;
    logic [PIX_W-1:0]     r_pix;
    logic [DST_W-1:0]     r_ox, r_oy;
    logic                 r_ofd;

    logic                 cfg_ok;
    logic [SRC_W-1:0]     anum, bnum;
    logic                 col_end, row_end;
    logic [SRC_W:0]       col_nxt, row_nxt, in_col_nxt, in_row_nxt;
    logic [SRC_W-1:0]     rd_col;
    logic [AW-1:0]        rd_addr;
    logic [ACC_BITS-1:0]  sum;
    logic                 clear_slot;
    logic [DIVD_BITS-1:0] div_q;
    logic                 div_done;
    logic [DIVD_BITS-1:0] dividend;

    always_comb begin
        cfg_ok = (r_src_w >= SRC_W'(2)) && (32'(r_src_w) <= MAX_SRC_SIZE)
              && (r_src_h >= SRC_W'(2)) && (32'(r_src_h) <= MAX_SRC_SIZE)
              && (r_dst_w != '0) && ({1'b0, r_dst_w} < r_src_w)
              && (32'(r_dst_w) <= MAX_DST_WIDTH)
              && (r_dst_h != '0) && ({1'b0, r_dst_h} < r_src_h);
        anum    = r_src_w - r_col_ph;
        bnum    = r_src_h - r_row_ph;
        col_end = anum <= {1'b0, r_dst_w};
        row_end = bnum <= {1'b0, r_dst_h};
        col_nxt    = {1'b0, r_col_ph} + {2'b00, r_dst_w};
        row_nxt    = {1'b0, r_row_ph} + {2'b00, r_dst_h};
        in_col_nxt = {1'b0, r_in_col} + 1'b1;
        in_row_nxt = {1'b0, r_in_row} + 1'b1;
        rd_col     = {1'b0, r_ex} + SRC_W'(i_cmd.term[0]);
        rd_addr    = {r_base_row0 ^ i_cmd.term[1], rd_col[CW-1:0]};
        sum        = r_rdata + r_p2;
        clear_slot = r_emit && (i_cmd.term == 2'd0);
        dividend   = DIVD_BITS'(r_sum) + DIVD_BITS'(r_area >> 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= RST_SRC_WIDTH;
            r_src_h <= RST_SRC_HEIGHT;
            r_dst_w <= RST_DST_WIDTH;
            r_dst_h <= RST_DST_HEIGHT;
        end else if (i_cfg_fire) begin
            case (i_cfg_index)
                REG_SRC_WIDTH:  r_src_w <= i_cfg_data;
                REG_SRC_HEIGHT: r_src_h <= i_cfg_data;
                REG_DST_WIDTH:  r_dst_w <= i_cfg_data[DST_W-1:0];
                REG_DST_HEIGHT: r_dst_h <= i_cfg_data[DST_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_fire) begin
            r_in_col <= '0;
            r_in_row <= '0;
            r_col_ph <= '0;
            r_row_ph <= '0;
            r_lo_col <= '0;
            r_lo_row <= '0;
        end else if (i_cmd.wr && i_cmd.last) begin
            if (in_col_nxt >= {1'b0, r_src_w}) begin
                r_in_col <= '0;
                r_col_ph <= '0;
                r_lo_col <= '0;
                if (in_row_nxt >= {1'b0, r_src_h}) begin
                    r_in_row <= '0;
                    r_row_ph <= '0;
                    r_lo_row <= '0;
                end else begin
                    r_in_row <= in_row_nxt[SRC_W-1:0];
                    if (row_nxt >= {1'b0, r_src_h}) begin
                        r_row_ph <= SRC_W'(row_nxt - {1'b0, r_src_h});
                        r_lo_row <= r_lo_row + 1'b1;
                    end else begin
                        r_row_ph <= row_nxt[SRC_W-1:0];
                    end
                end
            end else begin
                r_in_col <= in_col_nxt[SRC_W-1:0];
                if (col_nxt >= {1'b0, r_src_w}) begin
                    r_col_ph <= SRC_W'(col_nxt - {1'b0, r_src_w});
                    r_lo_col <= r_lo_col + 1'b1;
                end else begin
                    r_col_ph <= col_nxt[SRC_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit <= 1'b0;
        end else if (i_cmd.load) begin
            r_s         <= i_sample & SMASK;
            r_wx[0]     <= col_end ? anum[DST_W-1:0] : r_dst_w;
            r_wx[1]     <= col_end ? r_dst_w - anum[DST_W-1:0] : '0;
            r_wy[0]     <= row_end ? bnum[DST_W-1:0] : r_dst_h;
            r_wy[1]     <= row_end ? r_dst_h - bnum[DST_W-1:0] : '0;
            r_emit      <= col_end && row_end && (32'(r_lo_col) < MAX_DST_WIDTH);
            r_fdone     <= (r_lo_col == r_dst_w - 1'b1) && (r_lo_row == r_dst_h - 1'b1);
            r_ex        <= r_lo_col;
            r_ey        <= r_lo_row;
            r_base_row0 <= r_lo_row[0];
            r_area      <= r_src_w * r_src_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul1) begin
            r_p1 <= r_s * r_wx[i_cmd.term[0]];
        end
        if (i_cmd.mul2) begin
            r_p2     <= ACC_BITS'(r_p1 * r_wy[i_cmd.term[1]]);
            r_addr   <= rd_addr;
            r_wen_ok <= 32'(rd_col) < MAX_DST_WIDTH;
            r_rdata  <= r_mem[rd_addr];
        end
        if (i_cmd.wr && clear_slot) begin
            r_sum <= sum;
        end
        if (i_cmd.clr) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_cmd.wr && r_wen_ok) begin
            r_mem[r_addr] <= clear_slot ? '0 : sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_fire) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    aad_div #(.N(DIVD_BITS), .M(AREA_BITS)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (r_area),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
            r_pix       <= PIX_W'(div_q);
            r_ox        <= r_ex;
            r_oy        <= r_ey;
            r_ofd       <= r_fdone;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        o_sts.clr_last = r_clr_addr == {AW{1'b1}};
        o_sts.cfg_ok   = cfg_ok;
        o_sts.emit     = r_emit;
        o_sts.div_done = div_done;
        o_sts.out_full = r_out_valid && !i_out_ready;
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_value = r_pix;
    assign o_out_x       = r_ox;
    assign o_out_y       = r_oy;
    assign o_frame_done  = r_ofd;
endmodule
`default_nettype wire

// File: design/aad_ctrl.sv
// Controller: clearing sweep, four weighted read-modify-write terms per sample,
// divider launch and result hand-off. Depends on aad_pkg.
`default_nettype none
module aad_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_fire,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire aad_pkg::t_sts i_sts,
    output aad_pkg::t_cmd      o_cmd
);
    import aad_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_MUL1, S_MUL2, S_WR, S_DIV, S_DWAIT
    } t_state;

    t_state     r_state;
    logic [1:0] r_term;
    logic       in_fire;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd           = '0;
        o_cmd.term      = r_term;
        o_cmd.last      = (r_term == TERM_LAST);
        o_cmd.clr       = (r_state == S_CLEAR);
        o_cmd.load      = in_fire && i_sts.cfg_ok;
        o_cmd.mul1      = (r_state == S_MUL1);
        o_cmd.mul2      = (r_state == S_MUL2);
        o_cmd.wr        = (r_state == S_WR);
        o_cmd.div_start = (r_state == S_DIV);
        o_cmd.out_load  = (r_state == S_DWAIT) && i_sts.div_done && !i_sts.out_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_fire) begin
            r_state <= S_CLEAR;
            r_term  <= '0;
        end else begin
            case (r_state)
                S_CLEAR: if (i_sts.clr_last) r_state <= S_IDLE;
                S_IDLE: begin
                    if (in_fire && i_sts.cfg_ok) begin
                        r_state <= S_MUL1;
                        r_term  <= '0;
                    end
                end
                S_MUL1: r_state <= S_MUL2;
                S_MUL2: r_state <= S_WR;
                S_WR: begin
                    if (r_term == TERM_LAST) begin
                        r_state <= i_sts.emit ? S_DIV : S_IDLE;
                    end else begin
                        r_term  <= r_term + 1'b1;
                        r_state <= S_MUL1;
                    end
                end
                S_DIV: r_state <= S_DWAIT;
                S_DWAIT: begin
                    if (i_sts.div_done && !i_sts.out_full) r_state <= S_IDLE;
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: design/area_average_downscale.sv
// Area-average downscaler, top level. Each accepted sample runs as four
// multiply/read/write terms (MUL1, MUL2, WR) through one row-store port; a sample
// that completes a destination pixel then starts the divider on its dividend bits
// (SAMPLE_BITS + 2*clog2(MAX_SRC_SIZE) + 1, 41 by default) and waits for a free output.
// After reset and after every config write the row store (2**(clog2(MAX_DST_WIDTH)+1)
// entries, 8192 by default) is cleared in a sweep while no sample is taken.
`default_nettype none
module area_average_downscale #(
    parameter int MAX_DST_WIDTH = 4096,
    parameter int MAX_SRC_SIZE  = 4096,
    parameter int SAMPLE_BITS   = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [aad_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [aad_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [aad_pkg::PIX_W-1:0]      i_sample,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic [aad_pkg::PIX_W-1:0]           o_pixel_value,
    output logic [aad_pkg::DST_W-1:0]           o_out_x,
    output logic [aad_pkg::DST_W-1:0]           o_out_y,
    output logic                                o_frame_done
);
    import aad_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic cfg_fire;

    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid;

    aad_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_fire (cfg_fire),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    aad_dp #(
        .MAX_DST_WIDTH (MAX_DST_WIDTH),
        .MAX_SRC_SIZE  (MAX_SRC_SIZE),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_fire    (cfg_fire),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_sample      (i_sample),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_pixel_value (o_pixel_value),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_frame_done  (o_frame_done)
    );

    a_busy_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && sts.cfg_ok && !cfg_fire) |=> !o_in_ready)
        else $error("input still ready after a sample transfer");

    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.clr, cmd.wr}))
        else $error("clear and update write together");

    a_no_out_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_ready_not_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !cmd.clr)
        else $error("input ready during clearing sweep");
endmodule
`default_nettype wire
